// ----- rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// commands, widths and shared types of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int CMD_BITS = 4;
    localparam int RES_BITS = 33;
    localparam int WIDE_BITS = 64;
    localparam int SHIFT_BITS = 7;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD = 4'd0,
        CMD_SUB = 4'd1,
        CMD_MUL = 4'd2,
        CMD_DIV = 4'd3,
        CMD_LT  = 4'd4,
        CMD_GT  = 4'd5,
        CMD_LE  = 4'd6,
        CMD_GE  = 4'd7,
        CMD_EQ  = 4'd8,
        CMD_NE  = 4'd9
    } t_cmd;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture operands
        logic mul;       // form cross-products
        logic comb;      // combine products into num/den
        logic gcd_init;  // start gcd
        logic gcd_step;  // one gcd iteration
        logic div_init;  // start division by gcd
        logic div_step;  // one quotient bit
        logic finish;    // form the result registers
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic gcd_done;
        logic gcd_zero;
        logic div_done;
        logic is_arith;
    } t_stat;

endpackage

// ----- rtl/rau_ctrl.sv -----
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer of the rational arithmetic unit
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  rau_pkg::t_stat  i_stat,
    output rau_pkg::t_ctrl  o_ctrl
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_COMB, S_GINIT, S_GCD, S_DIV, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_ctrl.mul = 1'b1;
                n_state = S_COMB;
            end
            S_COMB: begin
                o_ctrl.comb = 1'b1;
                n_state = i_stat.is_arith ? S_GINIT : S_FIN;
            end
            // num/den are registered now, so their magnitudes can seed the gcd
            S_GINIT: begin
                o_ctrl.gcd_init = 1'b1;
                n_state = S_GCD;
            end
            S_GCD: begin
                if (i_stat.gcd_done) begin
                    if (i_stat.gcd_zero) begin
                        n_state = S_FIN;
                    end else begin
                        o_ctrl.div_init = 1'b1;
                        n_state = S_DIV;
                    end
                end else begin
                    o_ctrl.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_FIN;
                end else begin
                    o_ctrl.div_step = 1'b1;
                end
            end
            S_FIN: begin
                o_ctrl.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/rau_dp.sv -----
// ----------------------------------------------------------------------------
// rau_dp
// datapath: cross-products, compares, binary gcd, restoring division by the gcd
// ----------------------------------------------------------------------------
module rau_dp #(
    parameter int OPERAND_BITS = 16
) (
    input  logic                                i_clk,
    input  rau_pkg::t_ctrl                      i_ctrl,
    output rau_pkg::t_stat                      o_stat,
    input  logic [rau_pkg::CMD_BITS-1:0]        i_command,
    input  logic signed [OPERAND_BITS-1:0]      i_a_num,
    input  logic signed [OPERAND_BITS-1:0]      i_a_den,
    input  logic signed [OPERAND_BITS-1:0]      i_b_num,
    input  logic signed [OPERAND_BITS-1:0]      i_b_den,
    output logic signed [rau_pkg::RES_BITS-1:0] o_res_num,
    output logic signed [rau_pkg::RES_BITS-1:0] o_res_den,
    output logic                                o_flag
);

    localparam int W  = rau_pkg::WIDE_BITS;
    localparam int PB = 2 * OPERAND_BITS;
    localparam int SB = rau_pkg::SHIFT_BITS;

    logic [rau_pkg::CMD_BITS-1:0]   r_cmd;
    logic signed [OPERAND_BITS-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [PB-1:0]           r_p_ad, r_p_bc, r_p_ac, r_p_bd;
    logic [W-1:0]                   r_num, r_den;   // unreduced, two's complement
    logic [W-1:0]                   r_x, r_y;       // gcd working values
    logic [SB-1:0]                  r_k;
    logic                           r_gdone, r_gzero;
    logic [W-1:0]                   r_g;
    logic [W-1:0]                   r_qn, r_qd, r_rn, r_rd, r_mn, r_md;
    logic [SB-1:0]                  r_bit;
    logic                           r_ddone;
    logic [rau_pkg::RES_BITS-1:0]   r_onum, r_oden;
    logic                           r_oflag;

    logic          arith;
    logic [W-1:0]  mag_num, mag_den;
    logic [W-1:0]  rn_sh, rd_sh;
    logic [W-1:0]  q_num, q_den;
    logic          same;

    function automatic logic [W-1:0] sx(input logic signed [PB-1:0] v);
        sx = W'(v);
    endfunction

    assign arith   = (r_cmd <= rau_pkg::CMD_DIV);
    assign mag_num = r_num[W-1] ? (-r_num) : r_num;
    assign mag_den = r_den[W-1] ? (-r_den) : r_den;
    assign rn_sh   = {r_rn[W-2:0], r_mn[W-1]};
    assign rd_sh   = {r_rd[W-2:0], r_md[W-1]};
    assign q_num   = r_num[W-1] ? (-r_qn) : r_qn;
    assign q_den   = r_den[W-1] ? (-r_qd) : r_qd;
    assign same    = (r_an == r_bn) && (r_ad == r_bd);

    assign o_stat.gcd_done = r_gdone;
    assign o_stat.gcd_zero = r_gzero;
    assign o_stat.div_done = r_ddone;
    assign o_stat.is_arith = arith;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= i_command;
            r_an  <= i_a_num;
            r_ad  <= i_a_den;
            r_bn  <= i_b_num;
            r_bd  <= i_b_den;
        end
        if (i_ctrl.mul) begin
            r_p_ad <= PB'(r_an * r_bd);
            r_p_bc <= PB'(r_ad * r_bn);
            r_p_ac <= PB'(r_an * r_bn);
            r_p_bd <= PB'(r_ad * r_bd);
        end
        if (i_ctrl.comb) begin
            case (r_cmd)
                rau_pkg::CMD_ADD: begin
                    r_num <= sx(r_p_ad) + sx(r_p_bc);
                    r_den <= sx(r_p_bd);
                end
                rau_pkg::CMD_SUB: begin
                    r_num <= sx(r_p_ad) - sx(r_p_bc);
                    r_den <= sx(r_p_bd);
                end
                rau_pkg::CMD_MUL: begin
                    r_num <= sx(r_p_ac);
                    r_den <= sx(r_p_bd);
                end
                default: begin
                    r_num <= sx(r_p_ad);
                    r_den <= sx(r_p_bc);
                end
            endcase
        end
        // binary gcd, one step a cycle; magnitudes taken in the init cycle
        if (i_ctrl.gcd_init) begin
            r_x     <= mag_num;
            r_y     <= mag_den;
            r_k     <= '0;
            r_gdone <= 1'b0;
            r_gzero <= 1'b0;
        end else if (i_ctrl.gcd_step) begin
            if (r_x == '0 && r_y == '0 && r_k == '0 && !r_gdone) begin
                r_g     <= '0;
                r_gzero <= 1'b1;
                r_gdone <= 1'b1;
            end else if (r_x == '0) begin
                r_g     <= r_y << r_k;
                r_gdone <= 1'b1;
            end else if (r_y == '0) begin
                r_g     <= r_x << r_k;
                r_gdone <= 1'b1;
            end else if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + SB'(1);
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (r_x > r_y) begin
                r_x <= r_y;
                r_y <= r_x - r_y;
            end else begin
                r_y <= r_y - r_x;
            end
        end
        // restoring division of both magnitudes by g, one bit a cycle
        if (i_ctrl.div_init) begin
            r_mn    <= mag_num;
            r_md    <= mag_den;
            r_rn    <= '0;
            r_rd    <= '0;
            r_qn    <= '0;
            r_qd    <= '0;
            r_bit   <= '0;
            r_ddone <= 1'b0;
        end else if (i_ctrl.div_step) begin
            r_mn <= r_mn << 1;
            r_md <= r_md << 1;
            if (rn_sh >= r_g) begin
                r_rn <= rn_sh - r_g;
                r_qn <= {r_qn[W-2:0], 1'b1};
            end else begin
                r_rn <= rn_sh;
                r_qn <= {r_qn[W-2:0], 1'b0};
            end
            if (rd_sh >= r_g) begin
                r_rd <= rd_sh - r_g;
                r_qd <= {r_qd[W-2:0], 1'b1};
            end else begin
                r_rd <= rd_sh;
                r_qd <= {r_qd[W-2:0], 1'b0};
            end
            r_bit <= r_bit + SB'(1);
            if (r_bit == SB'(W - 1)) begin
                r_ddone <= 1'b1;
            end
        end
        if (i_ctrl.finish) begin
            if (arith) begin
                r_oflag <= 1'b0;
                if (r_gzero) begin
                    r_onum <= r_num[rau_pkg::RES_BITS-1:0];
                    r_oden <= r_den[rau_pkg::RES_BITS-1:0];
                end else begin
                    r_onum <= q_num[rau_pkg::RES_BITS-1:0];
                    r_oden <= q_den[rau_pkg::RES_BITS-1:0];
                end
            end else begin
                r_onum <= '0;
                r_oden <= '0;
                case (r_cmd)
                    rau_pkg::CMD_LT: r_oflag <= (r_p_ad <  r_p_bc);
                    rau_pkg::CMD_GT: r_oflag <= (r_p_ad >  r_p_bc);
                    rau_pkg::CMD_LE: r_oflag <= (r_p_ad <= r_p_bc);
                    rau_pkg::CMD_GE: r_oflag <= (r_p_ad >= r_p_bc);
                    rau_pkg::CMD_EQ: r_oflag <= same;
                    rau_pkg::CMD_NE: r_oflag <= !same;
                    default:         r_oflag <= 1'b0;
                endcase
            end
        end
    end

    assign o_res_num = r_onum;
    assign o_res_den = r_oden;
    assign o_flag    = r_oflag;

endmodule

// ----- rtl/rational_arith_unit_core.sv -----
// ----------------------------------------------------------------------------
// rational_arith_unit_core
// arithmetic and comparison on two fractions with gcd reduction
// ----------------------------------------------------------------------------
// comparisons go from the cross-products (EQ/NE: from the operands) straight
// to the result registers; arithmetic also runs the binary gcd loop and then a
// bit-serial division of both magnitudes by the gcd, skipped when the gcd is zero
// one transaction at a time; the next is taken the cycle after the result is taken
// reset: synchronous active low, clears the sequencer only
module rational_arith_unit_core #(
    parameter int OPERAND_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [rau_pkg::CMD_BITS-1:0]        i_command,
    input  logic signed [OPERAND_BITS-1:0]      i_a_num,
    input  logic signed [OPERAND_BITS-1:0]      i_a_den,
    input  logic signed [OPERAND_BITS-1:0]      i_b_num,
    input  logic signed [OPERAND_BITS-1:0]      i_b_den,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [rau_pkg::RES_BITS-1:0] o_res_num,
    output logic signed [rau_pkg::RES_BITS-1:0] o_res_den,
    output logic                                o_flag
);

    rau_pkg::t_ctrl ctrl;
    rau_pkg::t_stat stat;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_ctrl      (ctrl)
    );

    rau_dp #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
        .i_clk     (i_clk),
        .i_ctrl    (ctrl),
        .o_stat    (stat),
        .i_command (i_command),
        .i_a_num   (i_a_num),
        .i_a_den   (i_a_den),
        .i_b_num   (i_b_num),
        .i_b_den   (i_b_den),
        .o_res_num (o_res_num),
        .o_res_den (o_res_den),
        .o_flag    (o_flag)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output sides busy together");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("accepted a second transaction while busy");

    a_out_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> (o_in_ready && !o_out_valid))
        else $error("no return to idle after result taken");

endmodule
